>>> src/bqdf1_pkg.sv
`default_nettype none

package bqdf1_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEFF_W   = 24;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_CHANNELS_DEFAULT = 2;

    localparam int FRAC_SHIFT = 20;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);

    // Shared multiplier: wide operand holds a sample or the rounded sum,
    // narrow operand holds a coefficient that may have been negated.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = COEFF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Five Q5.43 products summed exactly, then rounded to 23 fraction bits.
    localparam int ACC_W = 51;
    localparam int MID_W = ACC_W - FRAC_SHIFT;
    localparam int Y_W   = PROD_W - FRAC_SHIFT;

    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

    localparam int TAP_COUNT = 5;
    localparam int TAP_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd5;

    localparam logic [TAP_W-1:0] TAP_X0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_X1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_X2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_Y1 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_Y2 = 3'd4;

    localparam logic signed [COEFF_W-1:0] COEFF_ONE = 24'sd1048576;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_RND  = 6'b001000,
        S_GAIN = 6'b010000,
        S_SAT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

>>> src/biquad_direct_form_one.sv
// An input is worked through S_MUL for each tap, then S_ACC, S_RND, S_GAIN and
// S_SAT; an input on a channel at or beyond NUM_CHANNELS goes straight to S_SAT.
// A new input is taken only once S_SAT has loaded its result, and the single
// shared multiplier forms the five tap products and then the output gain product in turn.
// Reset (aresetn low at a clock edge) clears both histories of every channel,
// loads the coefficients with b0 = 1.0, output gain = 1.0, others zero.
`default_nettype none

module biquad_direct_form_one #(
    parameter int NUM_CHANNELS = bqdf1_pkg::NUM_CHANNELS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [bqdf1_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bqdf1_pkg::COEFF_W-1:0]      cfg_wdata,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bqdf1_pkg::SAMPLE_W-1:0]     s_tdata,   // [23:0] sample_in
    input  wire logic                               s_tuser,   // [0] channel

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [bqdf1_pkg::SAMPLE_W-1:0]          m_tdata,   // [23:0] sample_out
    output logic [1:0]                              m_tuser    // [0] channel_out, [1] saturated
);

    localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int SampleW = bqdf1_pkg::SAMPLE_W;
    localparam int CoeffW  = bqdf1_pkg::COEFF_W;
    localparam int MulAW   = bqdf1_pkg::MUL_A_W;
    localparam int MulBW   = bqdf1_pkg::MUL_B_W;
    localparam int ProdW   = bqdf1_pkg::PROD_W;
    localparam int AccW    = bqdf1_pkg::ACC_W;
    localparam int MidW    = bqdf1_pkg::MID_W;
    localparam int YW      = bqdf1_pkg::Y_W;
    localparam int Frac    = bqdf1_pkg::FRAC_SHIFT;
    localparam int TapW    = bqdf1_pkg::TAP_W;

    localparam logic [TapW-1:0] LastTap = TapW'(bqdf1_pkg::TAP_COUNT - 1);

    bqdf1_pkg::state_t state_reg, state_next;

    logic [TapW-1:0]             tap_reg, tap_next;
    logic [ChIdxW-1:0]           ch_reg, ch_next;
    logic                        ch_bit_reg, ch_bit_next;
    logic                        ch_ok_reg, ch_ok_next;
    logic signed [SampleW-1:0]   x_reg, x_next;
    logic signed [ProdW-1:0]     prod_reg, prod_next;
    logic signed [AccW-1:0]      acc_reg, acc_next;
    logic signed [MidW-1:0]      mid_reg, mid_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [SampleW-1:0]          m_tdata_reg, m_tdata_next;
    logic [1:0]                  m_tuser_reg, m_tuser_next;

    logic signed [CoeffW-1:0]    ff_coeff_0_reg, ff_coeff_1_reg, ff_coeff_2_reg;
    logic signed [CoeffW-1:0]    fb_coeff_1_reg, fb_coeff_2_reg, output_gain_reg;

    logic signed [SampleW-1:0]   x1_reg [NUM_CHANNELS];
    logic signed [SampleW-1:0]   x2_reg [NUM_CHANNELS];
    logic signed [SampleW-1:0]   y1_reg [NUM_CHANNELS];
    logic signed [SampleW-1:0]   y2_reg [NUM_CHANNELS];

    logic                        s_xfer;
    logic                        out_load;
    logic                        hist_we;
    logic [ChIdxW-1:0]           s_ch_idx;
    logic                        s_ch_ok;
    logic signed [MulAW-1:0]     mul_a;
    logic signed [MulBW-1:0]     mul_b;
    logic signed [ProdW-1:0]     mul_p;
    logic signed [AccW-1:0]      acc_rnd;
    logic signed [ProdW-1:0]     prod_rnd;
    logic signed [YW-1:0]        y_full;
    logic signed [SampleW-1:0]   y_sat;
    logic                        y_clip;

    assign s_tready = (state_reg == bqdf1_pkg::S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_load = !m_tvalid_reg || m_tready;
    assign s_ch_idx = ChIdxW'(s_tuser);
    assign s_ch_ok  = (32'(s_tuser) < NUM_CHANNELS);
    assign hist_we  = (state_reg == bqdf1_pkg::S_SAT) && out_load && ch_ok_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        mul_a = MulAW'(x_reg);
        mul_b = MulBW'(ff_coeff_0_reg);
        if (state_reg == bqdf1_pkg::S_GAIN) begin
            mul_a = MulAW'(mid_reg);
            mul_b = MulBW'(output_gain_reg);
        end else begin
            case (tap_reg)
                bqdf1_pkg::TAP_X0: begin
                    mul_a = MulAW'(x_reg);
                    mul_b = MulBW'(ff_coeff_0_reg);
                end
                bqdf1_pkg::TAP_X1: begin
                    mul_a = MulAW'(x1_reg[ch_reg]);
                    mul_b = MulBW'(ff_coeff_1_reg);
                end
                bqdf1_pkg::TAP_X2: begin
                    mul_a = MulAW'(x2_reg[ch_reg]);
                    mul_b = MulBW'(ff_coeff_2_reg);
                end
                bqdf1_pkg::TAP_Y1: begin
                    mul_a = MulAW'(y1_reg[ch_reg]);
                    mul_b = -MulBW'(fb_coeff_1_reg);
                end
                bqdf1_pkg::TAP_Y2: begin
                    mul_a = MulAW'(y2_reg[ch_reg]);
                    mul_b = -MulBW'(fb_coeff_2_reg);
                end
                default: begin
                    mul_a = MulAW'(x_reg);
                    mul_b = MulBW'(ff_coeff_0_reg);
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // Round half up to 23 fraction bits: add half an LSB, then floor shift.
    assign acc_rnd  = acc_reg + AccW'(bqdf1_pkg::ROUND_BIAS);
    assign prod_rnd = prod_reg + ProdW'(bqdf1_pkg::ROUND_BIAS);
    assign y_full   = $signed(prod_rnd[ProdW-1:Frac]);

    always_comb begin
        if (y_full > YW'(bqdf1_pkg::SAMPLE_MAX)) begin
            y_sat  = SampleW'(bqdf1_pkg::SAMPLE_MAX);
            y_clip = 1'b1;
        end else if (y_full < YW'(bqdf1_pkg::SAMPLE_MIN)) begin
            y_sat  = SampleW'(bqdf1_pkg::SAMPLE_MIN);
            y_clip = 1'b1;
        end else begin
            y_sat  = y_full[SampleW-1:0];
            y_clip = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        ch_next       = ch_reg;
        ch_bit_next   = ch_bit_reg;
        ch_ok_next    = ch_ok_reg;
        x_next        = x_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        mid_next      = mid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            bqdf1_pkg::S_IDLE: begin
                if (s_xfer) begin
                    ch_next     = s_ch_idx;
                    ch_bit_next = s_tuser;
                    ch_ok_next  = s_ch_ok;
                    x_next      = $signed(s_tdata);
                    tap_next    = bqdf1_pkg::TAP_X0;
                    acc_next    = '0;
                    state_next  = s_ch_ok ? bqdf1_pkg::S_MUL : bqdf1_pkg::S_SAT;
                end
            end
            bqdf1_pkg::S_MUL: begin
                prod_next = mul_p;
                if (tap_reg != bqdf1_pkg::TAP_X0) begin
                    acc_next = acc_reg + $signed(prod_reg[AccW-1:0]);
                end
                if (tap_reg == LastTap) begin
                    state_next = bqdf1_pkg::S_ACC;
                end else begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            bqdf1_pkg::S_ACC: begin
                acc_next   = acc_reg + $signed(prod_reg[AccW-1:0]);
                state_next = bqdf1_pkg::S_RND;
            end
            bqdf1_pkg::S_RND: begin
                mid_next   = $signed(acc_rnd[AccW-1:Frac]);
                state_next = bqdf1_pkg::S_GAIN;
            end
            bqdf1_pkg::S_GAIN: begin
                prod_next  = mul_p;
                state_next = bqdf1_pkg::S_SAT;
            end
            bqdf1_pkg::S_SAT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    if (ch_ok_reg) begin
                        m_tdata_next = y_sat;
                        m_tuser_next = {y_clip, ch_bit_reg};
                    end else begin
                        m_tdata_next = '0;
                        m_tuser_next = {1'b0, ch_bit_reg};
                    end
                    state_next = bqdf1_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bqdf1_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bqdf1_pkg::S_IDLE;
            tap_reg      <= bqdf1_pkg::TAP_X0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ch_reg      <= ch_next;
        ch_bit_reg  <= ch_bit_next;
        ch_ok_reg   <= ch_ok_next;
        x_reg       <= x_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        mid_reg     <= mid_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_coeff_0_reg  <= bqdf1_pkg::COEFF_ONE;
            ff_coeff_1_reg  <= '0;
            ff_coeff_2_reg  <= '0;
            fb_coeff_1_reg  <= '0;
            fb_coeff_2_reg  <= '0;
            output_gain_reg <= bqdf1_pkg::COEFF_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bqdf1_pkg::REG_FF_COEFF_0:  ff_coeff_0_reg  <= $signed(cfg_wdata);
                bqdf1_pkg::REG_FF_COEFF_1:  ff_coeff_1_reg  <= $signed(cfg_wdata);
                bqdf1_pkg::REG_FF_COEFF_2:  ff_coeff_2_reg  <= $signed(cfg_wdata);
                bqdf1_pkg::REG_FB_COEFF_1:  fb_coeff_1_reg  <= $signed(cfg_wdata);
                bqdf1_pkg::REG_FB_COEFF_2:  fb_coeff_2_reg  <= $signed(cfg_wdata);
                bqdf1_pkg::REG_OUTPUT_GAIN: output_gain_reg <= $signed(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
        end else if (hist_we) begin
            x1_reg[ch_reg] <= x_reg;
            x2_reg[ch_reg] <= x1_reg[ch_reg];
            y1_reg[ch_reg] <= y_sat;
            y2_reg[ch_reg] <= y1_reg[ch_reg];
        end
    end

    a_acc_after_last_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bqdf1_pkg::S_ACC) |-> ($past(tap_reg) == LastTap))
        else $error("accumulate step entered before the last tap product");

    a_transfer_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg != bqdf1_pkg::S_IDLE))
        else $error("input transfer did not start a computation");

    a_history_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |=> ((x1_reg[ch_reg] == $past(x_reg)) && (y1_reg[ch_reg] == $past(y_sat))))
        else $error("history of the channel was not updated with the new sample");

    a_ignored_channel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == bqdf1_pkg::S_SAT) && out_load && !ch_ok_reg)
            |=> (m_tvalid && (m_tdata == '0) && !m_tuser[1]))
        else $error("result for an unused channel is not zero");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == bqdf1_pkg::S_SAT) && out_load) |=> m_tvalid)
        else $error("finished result was not presented");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
module tb_top;

    localparam int SAMPLE_W     = bqdf1_pkg::SAMPLE_W;
    localparam int COEFF_W      = bqdf1_pkg::COEFF_W;
    localparam int CFG_IDX_W    = bqdf1_pkg::CFG_IDX_W;
    localparam int FRAC_SHIFT   = bqdf1_pkg::FRAC_SHIFT;
    localparam int ROUND_BIAS   = bqdf1_pkg::ROUND_BIAS;
    localparam int SAMPLE_MAX   = bqdf1_pkg::SAMPLE_MAX;
    localparam int SAMPLE_MIN   = bqdf1_pkg::SAMPLE_MIN;
    localparam int NUM_CH       = bqdf1_pkg::NUM_CHANNELS_DEFAULT;

    localparam logic signed [COEFF_W-1:0] COEFF_ONE = bqdf1_pkg::COEFF_ONE;

    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_0  = bqdf1_pkg::REG_FF_COEFF_0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_1  = bqdf1_pkg::REG_FF_COEFF_1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_2  = bqdf1_pkg::REG_FF_COEFF_2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_1  = bqdf1_pkg::REG_FB_COEFF_1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFF_2  = bqdf1_pkg::REG_FB_COEFF_2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = bqdf1_pkg::REG_OUTPUT_GAIN;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 210;
    localparam int PHASE_COUNT    = 8;
    localparam int Q20_ONE        = 1 << FRAC_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef enum int {
        COEF_RESET_VALUES,
        COEF_TYPICAL,
        COEF_FULL_RANDOM,
        COEF_ALL_MAX,
        COEF_ALL_MIN
    } coef_set_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                ch;
        logic [SAMPLE_W-1:0] y;
        logic                sat;
    } filt_out_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic                 ch;
        logic [SAMPLE_W-1:0]  value;
        bit                   typed;
        logic [SAMPLE_W-1:0]  exp_y;
        logic                 exp_sat;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEFF_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;

    biquad_direct_form_one dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    logic signed [COEFF_W-1:0]  coeff [6] = '{COEFF_ONE, 0, 0, 0, 0, COEFF_ONE};
    logic signed [SAMPLE_W-1:0] x_hist [NUM_CH][2] = '{default: '0};
    logic signed [SAMPLE_W-1:0] y_hist [NUM_CH][2] = '{default: '0};
    logic [COEFF_W-1:0]         next_coeffs [6];

    filt_out_t pending_results [$];
    stim_row_t directed_rows [$];

    int mismatches     = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int saturated_seen = 0;
    int reg_writes     = 0;
    int coeff_sets     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    function automatic filt_out_t filter_step(input logic ch, input logic [SAMPLE_W-1:0] x);
        longint    acc;
        longint    mid;
        longint    y;
        filt_out_t r;
        acc = longint'($signed(x)) * longint'(coeff[REG_FF_COEFF_0])
            + longint'(x_hist[ch][0]) * longint'(coeff[REG_FF_COEFF_1])
            + longint'(x_hist[ch][1]) * longint'(coeff[REG_FF_COEFF_2])
            - longint'(y_hist[ch][0]) * longint'(coeff[REG_FB_COEFF_1])
            - longint'(y_hist[ch][1]) * longint'(coeff[REG_FB_COEFF_2]);
        mid = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
        y = (mid * longint'(coeff[REG_OUTPUT_GAIN]) + ROUND_BIAS) >>> FRAC_SHIFT;
        r.ch  = ch;
        r.sat = 1'b0;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            r.sat = 1'b1;
        end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
            r.sat = 1'b1;
        end
        r.y = y[SAMPLE_W-1:0];
        x_hist[ch][1] = x_hist[ch][0];
        x_hist[ch][0] = x;
        y_hist[ch][1] = y_hist[ch][0];
        y_hist[ch][0] = r.y;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] x,
                               input bit typed, input filt_out_t typed_res);
        filt_out_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = filter_step(ch, x);
        pending_results.push_back(typed ? typed_res : r);
        samples_sent++;
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx <= REG_OUTPUT_GAIN)
            coeff[idx] = val;
        reg_writes++;
    endtask

    task automatic load_coeffs();
        drain();
        for (int i = REG_FF_COEFF_0; i <= REG_OUTPUT_GAIN; i++)
            write_reg(CFG_IDX_W'(i), next_coeffs[i]);
        write_reg(REG_UNUSED_6, COEFF_W'($urandom));
        write_reg(REG_UNUSED_7, COEFF_W'($urandom));
        cfg_wr_en <= 1'b0;
        coeff_sets++;
    endtask

    // The receiver stalls at random, or for a long fixed stretch when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_result
        filt_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[1])
                saturated_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result ch=%0d y=%h sat=%0d",
                                          m_tuser[0], m_tdata, m_tuser[1]));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.ch)
                    report_mismatch($sformatf("channel %0d, expected %0d",
                                              m_tuser[0], want.ch));
                if (m_tdata !== want.y)
                    report_mismatch($sformatf("ch %0d sample %h, expected %h",
                                              want.ch, m_tdata, want.y));
                if (m_tuser[1] !== want.sat)
                    report_mismatch($sformatf("ch %0d saturated %0d, expected %0d",
                                              want.ch, m_tuser[1], want.sat));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        coef_set_t  set_kind;
        idle_mode_t idle_mode;
        bit         prev_cfg;
        stim_row_t  row;
        logic [SAMPLE_W-1:0] x;

        // Pass-through with reset coefficients, saturation at both ends, a saturated
        // value feeding back through history, writes to unused register indexes that
        // must change nothing, and a full coefficient set checked against filter_step.
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h000000, 1, 24'h000000, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h7FFFFF, 1, 24'h7FFFFF, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h800000, 1, 24'h800000, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h000001, 1, 24'h000001, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'hFFFFFF, 1, 24'hFFFFFF, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h555555, 1, 24'h555555, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'hAAAAAA, 1, 24'hAAAAAA, 1'b0});
        directed_rows.push_back('{1, REG_FF_COEFF_0, 1'b0, 24'h7FFFFF, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h7FFFFF, 1, 24'h7FFFFF, 1'b1});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h800000, 1, 24'h800000, 1'b1});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h000000, 1, 24'h000000, 1'b0});
        directed_rows.push_back('{1, REG_FF_COEFF_0, 1'b0, 24'h800000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h7FFFFF, 1, 24'h800000, 1'b1});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h800000, 1, 24'h7FFFFF, 1'b1});
        directed_rows.push_back('{1, REG_FF_COEFF_0, 1'b0, 24'h000000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_FB_COEFF_1, 1'b0, 24'hF00000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h123456, 1, 24'h800000, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h000000, 1, 24'h7FFFFF, 1'b0});
        directed_rows.push_back('{1, REG_UNUSED_6, 1'b0, 24'h000000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_UNUSED_7, 1'b0, 24'h000000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h000000, 1, 24'h800000, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h000000, 1, 24'h7FFFFF, 1'b0});
        directed_rows.push_back('{1, REG_FF_COEFF_0, 1'b0, 24'h080000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_FF_COEFF_1, 1'b0, 24'h040000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_FF_COEFF_2, 1'b0, 24'hFE0000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_FB_COEFF_1, 1'b0, 24'hF80000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_FB_COEFF_2, 1'b0, 24'h040000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_OUTPUT_GAIN, 1'b0, 24'h0C0000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h400000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'hC00000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h7FFFFF, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h000001, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h800000, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'h3FFFFF, 0, 24'h0, 1'b0});
        directed_rows.push_back('{1, REG_OUTPUT_GAIN, 1'b0, 24'h7FFFFF, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b0, 24'h00ABCD, 0, 24'h0, 1'b0});
        directed_rows.push_back('{0, REG_FF_COEFF_0, 1'b1, 24'hFF5432, 0, 24'h0, 1'b0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        prev_cfg = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!prev_cfg)
                    drain();
                write_reg(row.idx, row.value);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg)
                    cfg_wr_en <= 1'b0;
                send_sample(row.ch, row.value, row.typed, '{row.ch, row.exp_y, row.exp_sat});
                prev_cfg = 1'b0;
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       set_kind = COEF_RESET_VALUES;
                2, 6:    set_kind = COEF_FULL_RANDOM;
                3:       set_kind = COEF_ALL_MAX;
                5:       set_kind = COEF_ALL_MIN;
                default: set_kind = COEF_TYPICAL;
            endcase
            for (int i = REG_FF_COEFF_0; i <= REG_OUTPUT_GAIN; i++) begin
                case (set_kind)
                    COEF_RESET_VALUES:
                        next_coeffs[i] = (i == REG_FF_COEFF_0 || i == REG_OUTPUT_GAIN) ?
                                         COEFF_ONE : '0;
                    COEF_FULL_RANDOM: next_coeffs[i] = COEFF_W'($urandom);
                    COEF_ALL_MAX:     next_coeffs[i] = COEFF_W'(SAMPLE_MAX);
                    COEF_ALL_MIN:     next_coeffs[i] = COEFF_W'(SAMPLE_MIN);
                    default:
                        next_coeffs[i] = COEFF_W'($urandom_range(2 * Q20_ONE) - Q20_ONE);
                endcase
            end
            if (set_kind == COEF_TYPICAL) begin
                next_coeffs[REG_FB_COEFF_1] =
                    COEFF_W'($urandom_range(4 * Q20_ONE) - 2 * Q20_ONE);
                next_coeffs[REG_OUTPUT_GAIN] = COEFF_W'($urandom_range(Q20_ONE, Q20_ONE / 2));
            end
            load_coeffs();

            idle_mode = idle_mode_t'(p % 4);
            case (idle_mode)
                IDLE_SENDER:   begin send_idle_pct = 83; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                IDLE_BOTH:     begin send_idle_pct = 14; recv_stall_pct = 14; end
                default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Partway through one unthrottled phase the receiver holds off
                // long enough to back the block up into its input.
                if (p == 4 && n == 60)
                    hold_asks++;
                case ($urandom_range(9))
                    0:       x = SAMPLE_W'(SAMPLE_MAX);
                    1:       x = SAMPLE_W'(SAMPLE_MIN);
                    2:       x = SAMPLE_W'($urandom_range(2047) - 1024);
                    default: x = SAMPLE_W'($urandom);
                endcase
                sender_gap();
                send_sample(1'($urandom_range(1)), x, 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d samples over %0d coefficient sets and %0d register writes.",
                 samples_sent, coeff_sets + 1, reg_writes);
        $display("Checked %0d results, %0d of them clipped; %0d errors.",
                 results_seen, saturated_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
src/bqdf1_pkg.sv
src/biquad_direct_form_one.sv
dv/tb_top.sv
